/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and muted in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk while rst_n is high
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every rising edge of clk while rst_n is high
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition is followed by another in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mcwfb_pkg.sv */
// ----------------------------------------------------------------------------
// mcwfb_pkg
// Field widths, default sizes and request codes of the channel FIFO bank.
// ----------------------------------------------------------------------------
`default_nettype none

package mcwfb_pkg;

    // Port field widths
    localparam int REQ_W  = 3;
    localparam int ID_W   = 8;
    localparam int WORD_W = 32;
    localparam int GID_W  = 4;

    // Default bank geometry
    localparam int NUM_CHANNELS_DEF = 16;
    localparam int DEPTH_DEF        = 16;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE = 3'd0,
        REQ_CLOSE  = 3'd1,
        REQ_WRITE  = 3'd2,
        REQ_READ   = 3'd3,
        REQ_QUERY  = 3'd4
    } req_t;

endpackage

`default_nettype wire

/* hdl/multi_channel_word_fifo_bank.sv */
// ----------------------------------------------------------------------------
// multi_channel_word_fifo_bank
// Bank of NUM_CHANNELS circular word FIFOs with create, close, write, read
// and status requests, one request per clock.
// ----------------------------------------------------------------------------
// The bank takes a request on every clock where start is high; busy never
// rises. Each request gives exactly one result beat: the request is
// captured in an input register, decoded and applied to the
// channel tables and the shared word memory in the next cycle, and the
// result register (with the registered memory read port) drives done,
// status, granted_id, read_word and has_data for one cycle. The receiver
// cannot stall, so it must take each beat in the cycle that done is high.
// Words are held in one NUM_CHANNELS*DEPTH entry memory with one write and
// one read port; words that were never pushed are never popped.
`default_nettype none

`include "assert_macros.svh"

module multi_channel_word_fifo_bank #(
    parameter int NUM_CHANNELS = mcwfb_pkg::NUM_CHANNELS_DEF,
    parameter int DEPTH        = mcwfb_pkg::DEPTH_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [mcwfb_pkg::REQ_W-1:0]      req_type,
    input  wire logic [mcwfb_pkg::ID_W-1:0]       channel_id,
    input  wire logic [mcwfb_pkg::WORD_W-1:0]     write_word,
    output logic                                  done,
    output logic                                  status,
    output logic [mcwfb_pkg::GID_W-1:0]           granted_id,
    output logic [mcwfb_pkg::WORD_W-1:0]          read_word,
    output logic                                  has_data
);

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORDS  = NUM_CHANNELS * DEPTH;
    localparam int ADDR_W = $clog2(WORDS);
    localparam int LIM_W  = mcwfb_pkg::ID_W + 1;

    localparam logic [LIM_W-1:0] ID_LIMIT  = LIM_W'(NUM_CHANNELS);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

    // Advance a pointer with wrap at DEPTH
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    logic                               accept;

    // Input register
    logic                               req_valid_reg;
    logic [mcwfb_pkg::REQ_W-1:0]        req_type_reg;
    logic [mcwfb_pkg::ID_W-1:0]         channel_id_reg;
    logic [mcwfb_pkg::WORD_W-1:0]       write_word_reg;

    // Channel tables
    logic                               active_reg [NUM_CHANNELS];
    logic                               active_next [NUM_CHANNELS];
    logic [PTR_W-1:0]                   head_reg [NUM_CHANNELS];
    logic [PTR_W-1:0]                   head_next [NUM_CHANNELS];
    logic [PTR_W-1:0]                   tail_reg [NUM_CHANNELS];
    logic [PTR_W-1:0]                   tail_next [NUM_CHANNELS];
    logic [CNT_W-1:0]                   fill_reg [NUM_CHANNELS];
    logic [CNT_W-1:0]                   fill_next [NUM_CHANNELS];

    // Word memory
    logic [mcwfb_pkg::WORD_W-1:0]       word_mem [WORDS];
    logic [mcwfb_pkg::WORD_W-1:0]       rd_word_reg;
    logic                               mem_we;
    logic                               rd_en;
    logic [ADDR_W-1:0]                  base_addr;
    logic [ADDR_W-1:0]                  wr_addr;
    logic [ADDR_W-1:0]                  rd_addr;

    // Decode signals
    logic [CH_W-1:0]                    ch_idx;
    logic                               id_ok;
    logic                               usable;
    logic [PTR_W-1:0]                   head_cur;
    logic [PTR_W-1:0]                   tail_cur;
    logic [CNT_W-1:0]                   fill_cur;
    logic                               free_found;
    logic [CH_W-1:0]                    free_idx;

    // Result register
    logic                               done_reg;
    logic                               status_reg;
    logic                               status_next;
    logic [mcwfb_pkg::GID_W-1:0]        granted_id_reg;
    logic [mcwfb_pkg::GID_W-1:0]        granted_id_next;
    logic                               has_data_reg;
    logic                               has_data_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Capture the request beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg   <= req_type;
            channel_id_reg <= channel_id;
            write_word_reg <= write_word;
        end
    end

    // Look up the addressed channel
    assign ch_idx   = channel_id_reg[CH_W-1:0];
    assign id_ok    = {1'b0, channel_id_reg} < ID_LIMIT;
    assign usable   = id_ok && active_reg[ch_idx];
    assign head_cur = head_reg[ch_idx];
    assign tail_cur = tail_reg[ch_idx];
    assign fill_cur = fill_reg[ch_idx];

    assign base_addr = ADDR_W'(ch_idx) * ADDR_W'(DEPTH);
    assign wr_addr   = base_addr + ADDR_W'(tail_cur);
    assign rd_addr   = base_addr + ADDR_W'(head_cur);

    // Find the lowest free channel
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = CH_W'(i);
            end
        end
    end

    // Decode the request and update the tables
    always_comb
    begin
        active_next     = active_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        status_next     = 1'b1;
        granted_id_next = '0;
        has_data_next   = 1'b0;

        if (req_valid_reg)
        begin
            case (mcwfb_pkg::req_t'(req_type_reg))
                mcwfb_pkg::REQ_CREATE:
                begin
                    if (free_found)
                    begin
                        active_next[free_idx] = 1'b1;
                        head_next[free_idx]   = '0;
                        tail_next[free_idx]   = '0;
                        fill_next[free_idx]   = '0;
                        status_next           = 1'b0;
                        granted_id_next       = mcwfb_pkg::GID_W'(free_idx);
                    end
                end
                mcwfb_pkg::REQ_CLOSE:
                begin
                    if (usable)
                    begin
                        active_next[ch_idx] = 1'b0;
                        status_next         = 1'b0;
                    end
                end
                mcwfb_pkg::REQ_WRITE:
                begin
                    if (usable && (fill_cur != CNT_FULL))
                    begin
                        mem_we            = 1'b1;
                        tail_next[ch_idx] = ptr_inc(tail_cur);
                        fill_next[ch_idx] = fill_cur + 1'b1;
                        status_next       = 1'b0;
                    end
                end
                mcwfb_pkg::REQ_READ:
                begin
                    if (usable && (fill_cur != '0))
                    begin
                        rd_en             = 1'b1;
                        head_next[ch_idx] = ptr_inc(head_cur);
                        fill_next[ch_idx] = fill_cur - 1'b1;
                        status_next       = 1'b0;
                    end
                end
                mcwfb_pkg::REQ_QUERY:
                begin
                    if (usable)
                    begin
                        status_next   = 1'b0;
                        has_data_next = (fill_cur != '0);
                    end
                end
                default:
                begin
                    status_next = 1'b1;
                end
            endcase
        end
    end

    // Hold the channel tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '{default: '0};
            head_reg   <= '{default: '0};
            tail_reg   <= '{default: '0};
            fill_reg   <= '{default: '0};
        end
        else
        begin
            active_reg <= active_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
        end
    end

    // Push and pop words; drop read data to zero when nothing is popped
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            word_mem[wr_addr] <= write_word_reg;
        end
        if (rd_en)
        begin
            rd_word_reg <= word_mem[rd_addr];
        end
        else
        begin
            rd_word_reg <= '0;
        end
    end

    // Launch the result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        granted_id_reg <= granted_id_next;
        has_data_reg   <= has_data_next;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign granted_id = granted_id_reg;
    assign read_word  = rd_word_reg;
    assign has_data   = has_data_reg;

    // Checks
    `ASSERT_NEXT(a_beat_follows_req, req_valid_reg, done, "request produced no result beat")
    `ASSERT_IMPLY(a_fill_bounded, (req_valid_reg && id_ok), (fill_cur <= CNT_FULL),
        "channel fill count exceeds depth")
    `ASSERT_IMPLY(a_error_clean, (done && status),
        ((granted_id == '0) && (read_word == '0) && !has_data), "error beat carries data")
    `ASSERT_IMPLY(a_no_double_op, (mem_we || rd_en), (mem_we != rd_en),
        "write and read issued together")

endmodule

`default_nettype wire

/* sim/multi_channel_word_fifo_bank_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_channel_word_fifo_bank_tb
// Self-checking bench for the channel FIFO bank. Sends a directed opening and
// then random request streams built from fill, drain and claim bursts mixed
// with single requests and noise. Each accepted request feeds a behavioral
// model of the bank, and each result beat is checked against the oldest
// predicted beat.
// ----------------------------------------------------------------------------

module multi_channel_word_fifo_bank_tb;

    localparam int CHANNELS       = mcwfb_pkg::NUM_CHANNELS_DEF;
    localparam int FIFO_DEPTH     = mcwfb_pkg::DEPTH_DEF;
    localparam int REQ_W          = mcwfb_pkg::REQ_W;
    localparam int ID_W           = mcwfb_pkg::ID_W;
    localparam int WORD_W         = mcwfb_pkg::WORD_W;
    localparam int GID_W          = mcwfb_pkg::GID_W;
    localparam int REQ_CODE_MAX   = (1 << REQ_W) - 1;
    localparam int ID_MAX         = (1 << ID_W) - 1;
    localparam int HALF_PERIOD_NS = 2;
    localparam int RESET_CYCLES   = 6;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 175;
    localparam int REPORT_MAX     = 40;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // One result beat, tagged with the request that caused it
    typedef struct {
        logic [REQ_W-1:0]  code;
        logic [ID_W-1:0]   chan;
        logic              status;
        logic [GID_W-1:0]  gid;
        logic [WORD_W-1:0] word;
        logic              has_data;
    } bank_beat_t;

    // ------------------------------------------------------------------------
    // Channel bank model and result checker
    // ------------------------------------------------------------------------
    class fifo_bank_scoreboard;
        bit                chan_open  [CHANNELS];
        int unsigned       head_ptr   [CHANNELS];
        int unsigned       tail_ptr   [CHANNELS];
        int unsigned       fill_level [CHANNELS];
        logic [WORD_W-1:0] words      [CHANNELS][FIFO_DEPTH];
        bank_beat_t        expected_beats[$];
        int unsigned       mismatches;
        int unsigned       beats_checked;
        int unsigned       n_granted;
        int unsigned       n_popped;
        int unsigned       n_full;
        int unsigned       n_empty;
        int unsigned       n_no_free;
        int unsigned       n_bad;

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("MISMATCH @%0t: %s", $time, what);
        endtask

        // Apply one accepted request and queue the beat it must produce
        function void note_request(logic [REQ_W-1:0] code, logic [ID_W-1:0] chan,
                                   logic [WORD_W-1:0] wr_word);
            bank_beat_t  beat;
            bit          usable;
            int unsigned c;
            beat.code     = code;
            beat.chan     = chan;
            beat.status   = STATUS_ERR;
            beat.gid      = '0;
            beat.word     = '0;
            beat.has_data = 1'b0;
            c      = chan;
            usable = 1'b0;
            if (c < CHANNELS)
                usable = chan_open[c];
            case (code)
                mcwfb_pkg::REQ_CREATE:
                begin
                    // Claim the lowest free channel and clear its pointers
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (!chan_open[i])
                        begin
                            chan_open[i]  = 1'b1;
                            head_ptr[i]   = 0;
                            tail_ptr[i]   = 0;
                            fill_level[i] = 0;
                            beat.status   = STATUS_OK;
                            beat.gid      = GID_W'(i);
                            n_granted++;
                            break;
                        end
                    end
                    if (beat.status == STATUS_ERR)
                        n_no_free++;
                end
                mcwfb_pkg::REQ_CLOSE:
                begin
                    if (usable)
                    begin
                        chan_open[c] = 1'b0;
                        beat.status  = STATUS_OK;
                    end
                    else
                        n_bad++;
                end
                mcwfb_pkg::REQ_WRITE:
                begin
                    if (!usable)
                        n_bad++;
                    else if (fill_level[c] == FIFO_DEPTH)
                        n_full++;
                    else
                    begin
                        words[c][tail_ptr[c]] = wr_word;
                        tail_ptr[c]           = (tail_ptr[c] + 1) % FIFO_DEPTH;
                        fill_level[c]++;
                        beat.status = STATUS_OK;
                    end
                end
                mcwfb_pkg::REQ_READ:
                begin
                    if (!usable)
                        n_bad++;
                    else if (fill_level[c] == 0)
                        n_empty++;
                    else
                    begin
                        beat.word   = words[c][head_ptr[c]];
                        head_ptr[c] = (head_ptr[c] + 1) % FIFO_DEPTH;
                        fill_level[c]--;
                        beat.status = STATUS_OK;
                        n_popped++;
                    end
                end
                mcwfb_pkg::REQ_QUERY:
                begin
                    if (usable)
                    begin
                        beat.status   = STATUS_OK;
                        beat.has_data = (fill_level[c] != 0);
                    end
                    else
                        n_bad++;
                end
                default:
                begin
                    // Unknown code: error, nothing changes
                end
            endcase
            expected_beats.push_back(beat);
        endfunction

        // Compare one result beat with the oldest prediction
        task check_beat(logic status, logic [GID_W-1:0] gid, logic [WORD_W-1:0] word,
                        logic has_data);
            bank_beat_t want;
            if (expected_beats.size() == 0)
            begin
                report_mismatch("result beat with no request outstanding");
                return;
            end
            want = expected_beats.pop_front();
            beats_checked++;
            if ({status, gid, word, has_data} !==
                {want.status, want.gid, want.word, want.has_data})
                report_mismatch($sformatf(
                    "req %0d ch %0d: got %b/%0d/%h/%b, want %b/%0d/%h/%b",
                    want.code, want.chan, status, gid, word, has_data,
                    want.status, want.gid, want.word, want.has_data));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT and signals
    // ------------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [REQ_W-1:0]  req_type;
    logic [ID_W-1:0]   channel_id;
    logic [WORD_W-1:0] write_word;
    logic              done;
    logic              status;
    logic [GID_W-1:0]  granted_id;
    logic [WORD_W-1:0] read_word;
    logic              has_data;

    fifo_bank_scoreboard bank_model;
    int unsigned         sender_idle_pct;
    int unsigned         items_sent;
    int unsigned         stall_cycles;

    always #HALF_PERIOD_NS clk = ~clk;

    multi_channel_word_fifo_bank #(
        .NUM_CHANNELS (CHANNELS),
        .DEPTH        (FIFO_DEPTH)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .channel_id (channel_id),
        .write_word (write_word),
        .done       (done),
        .status     (status),
        .granted_id (granted_id),
        .read_word  (read_word),
        .has_data   (has_data)
    );

    // Check every result beat in the cycle that done is high
    always @(posedge clk)
    begin
        if (rst_n && done)
            bank_model.check_beat(status, granted_id, read_word, has_data);
    end

    // End the run if neither a request nor a result beat moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("multi_channel_word_fifo_bank_tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------------

    // Drive one request from a falling edge, hold until taken, note it
    task automatic send_request(input logic [REQ_W-1:0] code, input logic [ID_W-1:0] chan,
                                input logic [WORD_W-1:0] wr_word);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start      = 1'b1;
        req_type   = code;
        channel_id = chan;
        write_word = wr_word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        bank_model.note_request(code, chan, wr_word);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return '1;
        if (roll < 16)
            return '0;
        return $urandom();
    endfunction

    // Favor open channels, with some closed and out-of-range ids mixed in
    function automatic logic [ID_W-1:0] pick_channel();
        int unsigned open_list[$];
        int unsigned roll;
        roll = $urandom_range(99);
        foreach (bank_model.chan_open[i])
            if (bank_model.chan_open[i])
                open_list.push_back(i);
        if (roll < 10)
            return ID_W'($urandom_range(ID_MAX, CHANNELS));
        if (roll < 80 && open_list.size() != 0)
            return ID_W'(open_list[$urandom_range(open_list.size() - 1)]);
        return ID_W'($urandom_range(CHANNELS - 1));
    endfunction

    // Write one channel past full, or read it past empty; a closed or bad id gets one to three requests
    task automatic stream_burst(input logic [REQ_W-1:0] code);
        logic [ID_W-1:0] chan;
        int unsigned     n_beats;
        chan    = pick_channel();
        n_beats = $urandom_range(3, 1);
        if (chan < CHANNELS && bank_model.chan_open[chan])
        begin
            if (code == mcwfb_pkg::REQ_WRITE)
                n_beats = FIFO_DEPTH + 1 - bank_model.fill_level[chan];
            else
                n_beats = bank_model.fill_level[chan] + 1;
        end
        repeat (n_beats)
            send_request(code, chan, random_word());
    endtask

    // Create until the bank refuses
    task automatic claim_burst();
        int unsigned n_free;
        n_free = 0;
        foreach (bank_model.chan_open[i])
            if (!bank_model.chan_open[i])
                n_free++;
        repeat (n_free + 1)
            send_request(mcwfb_pkg::REQ_CREATE, ID_W'($urandom_range(ID_MAX)),
                         random_word());
    endtask

    task automatic single_request(input int unsigned write_pct);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 7)
            send_request(mcwfb_pkg::REQ_CREATE, ID_W'($urandom_range(ID_MAX)),
                         random_word());
        else if (roll < 12)
            send_request(mcwfb_pkg::REQ_CLOSE, pick_channel(), random_word());
        else if (roll < 12 + write_pct)
            send_request(mcwfb_pkg::REQ_WRITE, pick_channel(), random_word());
        else if (roll < 87)
            send_request(mcwfb_pkg::REQ_READ, pick_channel(), random_word());
        else if (roll < 96)
            send_request(mcwfb_pkg::REQ_QUERY, pick_channel(), random_word());
        else
            send_request(REQ_W'($urandom_range(REQ_CODE_MAX, mcwfb_pkg::REQ_QUERY + 1)),
                         ID_W'($urandom_range(ID_MAX)), random_word());
    endtask

    // Mix bursts and single requests until n_items more have gone in
    task automatic run_random(input int unsigned n_items, input int unsigned write_pct);
        int unsigned target;
        int unsigned roll;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            roll = $urandom_range(99);
            if (roll < 8)
                stream_burst(mcwfb_pkg::REQ_WRITE);
            else if (roll < 16)
                stream_burst(mcwfb_pkg::REQ_READ);
            else if (roll < 19)
                claim_burst();
            else
                single_request(write_pct);
        end
    endtask

    // Opening sequence: every request kind, field extremes, error paths
    task automatic run_directed();
        send_request(mcwfb_pkg::REQ_READ, '0, '0);                 // closed channel
        send_request(mcwfb_pkg::REQ_QUERY, ID_W'(ID_MAX), '1);     // id far out of range
        send_request(mcwfb_pkg::REQ_CREATE, ID_W'(ID_MAX), '1);    // id ignored, grants 0
        send_request(mcwfb_pkg::REQ_WRITE, '0, '1);
        send_request(mcwfb_pkg::REQ_WRITE, '0, '0);
        send_request(mcwfb_pkg::REQ_QUERY, '0, '0);                // holds data
        send_request(mcwfb_pkg::REQ_READ, '0, '1);
        send_request(mcwfb_pkg::REQ_READ, '0, '1);
        send_request(mcwfb_pkg::REQ_READ, '0, '0);                 // now empty
        send_request(mcwfb_pkg::REQ_QUERY, '0, '0);                // open but empty
        send_request(mcwfb_pkg::REQ_WRITE, ID_W'(CHANNELS), '1);   // first bad id
        send_request(mcwfb_pkg::REQ_WRITE, ID_W'(ID_MAX), '1);
        for (int code = mcwfb_pkg::REQ_QUERY + 1; code <= REQ_CODE_MAX; code++)
            send_request(REQ_W'(code), '0, '1);                    // unknown codes
        send_request(mcwfb_pkg::REQ_CREATE, '0, '0);               // grants 1
        send_request(mcwfb_pkg::REQ_WRITE, '0, 32'hA5A5_5A5A);
        send_request(mcwfb_pkg::REQ_CLOSE, '0, '0);
        send_request(mcwfb_pkg::REQ_CLOSE, '0, '0);                // already closed
        send_request(mcwfb_pkg::REQ_WRITE, '0, '1);                // closed channel
        send_request(mcwfb_pkg::REQ_CREATE, '0, '0);               // reuses 0, pointers cleared
        send_request(mcwfb_pkg::REQ_QUERY, '0, '0);
        send_request(mcwfb_pkg::REQ_READ, '0, '0);
        send_request(mcwfb_pkg::REQ_CLOSE, ID_W'(1), '0);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        req_type        = '0;
        channel_id      = '0;
        write_word      = '0;
        items_sent      = 0;
        stall_cycles    = 0;
        sender_idle_pct = 17;
        bank_model      = new;
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Light sender gaps, then heavy gaps, then back-to-back requests
        run_directed();
        run_random(PHASE_ITEMS, 45);
        sender_idle_pct = 76;
        run_random(PHASE_ITEMS, 30);
        sender_idle_pct = 0;
        run_random(PHASE_ITEMS, 37);
        start = 1'b0;

        // Drain outstanding beats, then watch for strays
        while (bank_model.expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Sent %0d requests, checked %0d beats: %0d channels granted, %0d words popped.",
                 items_sent, bank_model.beats_checked, bank_model.n_granted,
                 bank_model.n_popped);
        $display("Rejected: %0d full writes, %0d empty reads, %0d creates, %0d bad or closed ids.",
                 bank_model.n_full, bank_model.n_empty, bank_model.n_no_free, bank_model.n_bad);
        if (bank_model.mismatches == 0 && bank_model.expected_beats.size() == 0)
            $display("multi_channel_word_fifo_bank_tb: PASS");
        else
            $display("multi_channel_word_fifo_bank_tb: FAIL");
        $finish;
    end

endmodule
